// ===== rtl/lmrq_pkg.sv =====
`timescale 1ns / 1ps

package lmrq_pkg;

  localparam int unsigned MAX_NODES_DEF  = 16;
  localparam int unsigned CLOCK_BITS_DEF = 32;
  localparam int unsigned ID_W           = 4;
  localparam int unsigned FUNC_W         = 2;
  localparam int unsigned PORT_CLK_W     = 32;
  localparam int unsigned PORT_CNT_W     = 5;

  typedef enum logic [FUNC_W-1:0] {
    FUNC_LOCAL_REQ = 2'd0,
    FUNC_PEER_REQ  = 2'd1,
    FUNC_PEER_REL  = 2'd2,
    FUNC_LOCAL_REL = 2'd3
  } func_e;

  typedef struct packed {
    func_e                 func;
    logic [ID_W-1:0]       entry_id;
    logic [PORT_CLK_W-1:0] entry_clock;
  } in_item_t;

  typedef struct packed {
    logic [PORT_CLK_W-1:0] clock_now;
    logic                  own_at_front;
    logic [PORT_CNT_W-1:0] entry_count;
    logic                  overflow;
    logic                  not_found;
  } out_item_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_DISP,
    ST_INS_RD,
    ST_INS_CMP,
    ST_RM_RD,
    ST_RM_CMP,
    ST_SH_RD,
    ST_SH_WR,
    ST_FIN
  } state_e;

  typedef enum logic [1:0] {
    RD_PTR_M1,
    RD_PTR,
    RD_PTR_P1
  } rd_sel_e;

  typedef struct packed {
    logic    accept;
    logic    ptr_to_cnt;
    logic    ptr_to_zero;
    logic    ptr_dec;
    logic    ptr_inc;
    logic    rd_en;
    rd_sel_e rd_sel;
    logic    wr_en;
    logic    wr_new;
    logic    cnt_inc;
    logic    cnt_dec;
    logic    set_ovf;
    logic    set_nf;
    logic    load_out;
  } ctrl_cmd_t;

  typedef struct packed {
    logic is_insert;
    logic is_full;
    logic ptr_zero;
    logic ptr_at_cnt;
    logic ptr_next_at_cnt;
    logic rd_greater;
    logic rd_match;
  } ctrl_sts_t;

endpackage

// ===== rtl/lamport_mutex_request_queue_top.sv =====
`timescale 1ns / 1ps
// Channel  Signals                              Dir  Payload
// cfg      cfg_valid_i / cfg_ready_o            in   own node id (4 bits)
// in       in_valid_i / in_ready_o              in   lmrq_pkg::in_item_t
// out      out_valid_o / out_ready_i            out  lmrq_pkg::out_item_t
//
// One item at a time. Insert: each entry greater than the new key is shifted up one slot,
// then the key is written below them; insert into a full queue only sets overflow. Release:
// search from slot 0 for the id, then shift later entries down. The queue read is registered.
// Reset clears clock, count and node id; queue contents need no clearing.
// A waiting result sits in the output register; the next item is taken meanwhile
// and only its finish step waits for the output slot.

module lamport_mutex_request_queue_top #(
  parameter int unsigned MAX_NODES  = lmrq_pkg::MAX_NODES_DEF,
  parameter int unsigned CLOCK_BITS = lmrq_pkg::CLOCK_BITS_DEF
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      cfg_valid_i,
  output logic                      cfg_ready_o,
  input  logic [lmrq_pkg::ID_W-1:0] cfg_data_i,
  input  logic                      in_valid_i,
  output logic                      in_ready_o,
  input  lmrq_pkg::in_item_t        in_data_i,
  output logic                      out_valid_o,
  input  logic                      out_ready_i,
  output lmrq_pkg::out_item_t       out_data_o
);
  import lmrq_pkg::*;

  ctrl_cmd_t cmd;
  ctrl_sts_t sts;

  assign cfg_ready_o = 1'b1;

  lmrq_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  lmrq_dp #(
    .MAX_NODES  (MAX_NODES),
    .CLOCK_BITS (CLOCK_BITS)
  ) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_data_i  (cfg_data_i),
    .in_data_i   (in_data_i),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .out_data_o  (out_data_o)
  );

endmodule

// ===== rtl/lmrq_ctrl.sv =====
`timescale 1ns / 1ps

module lmrq_ctrl (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  input  lmrq_pkg::ctrl_sts_t sts_i,
  output lmrq_pkg::ctrl_cmd_t cmd_o
);
  import lmrq_pkg::*;

  state_e state_q, state_d;
  logic   out_valid_q, out_valid_d;

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (in_valid_i) state_d = ST_DISP;
      end
      ST_DISP: begin
        if (sts_i.is_insert) state_d = sts_i.is_full ? ST_FIN : ST_INS_RD;
        else state_d = ST_RM_RD;
      end
      ST_INS_RD: begin
        state_d = sts_i.ptr_zero ? ST_FIN : ST_INS_CMP;
      end
      ST_INS_CMP: begin
        state_d = sts_i.rd_greater ? ST_INS_RD : ST_FIN;
      end
      ST_RM_RD: begin
        state_d = sts_i.ptr_at_cnt ? ST_FIN : ST_RM_CMP;
      end
      ST_RM_CMP: begin
        state_d = sts_i.rd_match ? ST_SH_RD : ST_RM_RD;
      end
      ST_SH_RD: begin
        state_d = sts_i.ptr_next_at_cnt ? ST_FIN : ST_SH_WR;
      end
      ST_SH_WR: begin
        state_d = ST_SH_RD;
      end
      ST_FIN: begin
        if (!out_valid_q || out_ready_i) state_d = ST_IDLE;
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    cmd_o        = '0;
    cmd_o.rd_sel = RD_PTR;
    case (state_q)
      ST_IDLE: begin
        cmd_o.accept = in_valid_i;
      end
      ST_DISP: begin
        if (sts_i.is_insert) begin
          if (sts_i.is_full) cmd_o.set_ovf = 1'b1;
          else cmd_o.ptr_to_cnt = 1'b1;
        end else begin
          cmd_o.ptr_to_zero = 1'b1;
        end
      end
      ST_INS_RD: begin
        if (sts_i.ptr_zero) begin
          cmd_o.wr_en   = 1'b1;
          cmd_o.wr_new  = 1'b1;
          cmd_o.cnt_inc = 1'b1;
        end else begin
          cmd_o.rd_en  = 1'b1;
          cmd_o.rd_sel = RD_PTR_M1;
        end
      end
      ST_INS_CMP: begin
        // shift the larger entry up one slot, or drop the new key here
        cmd_o.wr_en = 1'b1;
        if (sts_i.rd_greater) begin
          cmd_o.ptr_dec = 1'b1;
        end else begin
          cmd_o.wr_new  = 1'b1;
          cmd_o.cnt_inc = 1'b1;
        end
      end
      ST_RM_RD: begin
        if (sts_i.ptr_at_cnt) cmd_o.set_nf = 1'b1;
        else cmd_o.rd_en = 1'b1;
      end
      ST_RM_CMP: begin
        cmd_o.ptr_inc = !sts_i.rd_match;
      end
      ST_SH_RD: begin
        if (sts_i.ptr_next_at_cnt) begin
          cmd_o.cnt_dec = 1'b1;
        end else begin
          cmd_o.rd_en  = 1'b1;
          cmd_o.rd_sel = RD_PTR_P1;
        end
      end
      ST_SH_WR: begin
        cmd_o.wr_en   = 1'b1;
        cmd_o.ptr_inc = 1'b1;
      end
      ST_FIN: begin
        cmd_o.load_out = !out_valid_q || out_ready_i;
      end
      default: begin
        cmd_o = '0;
      end
    endcase
  end

  always_comb begin
    if (cmd_o.load_out) out_valid_d = 1'b1;
    else if (out_ready_i) out_valid_d = 1'b0;
    else out_valid_d = out_valid_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign in_ready_o  = (state_q == ST_IDLE);
  assign out_valid_o = out_valid_q;

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o) |=> (state_q == ST_DISP))
    else $error("accepted item not dispatched");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_FIN && out_valid_q && !out_ready_i) |=> (state_q == ST_FIN))
    else $error("result left finish while output slot busy");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.load_out |=> out_valid_o)
    else $error("loaded result not presented");

endmodule

// ===== rtl/lmrq_dp.sv =====
`timescale 1ns / 1ps

module lmrq_dp #(
  parameter int unsigned MAX_NODES  = lmrq_pkg::MAX_NODES_DEF,
  parameter int unsigned CLOCK_BITS = lmrq_pkg::CLOCK_BITS_DEF
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      cfg_valid_i,
  input  logic [lmrq_pkg::ID_W-1:0] cfg_data_i,
  input  lmrq_pkg::in_item_t        in_data_i,
  input  lmrq_pkg::ctrl_cmd_t       cmd_i,
  output lmrq_pkg::ctrl_sts_t       sts_o,
  output lmrq_pkg::out_item_t       out_data_o
);
  import lmrq_pkg::*;

  localparam int unsigned CNT_W  = $clog2(MAX_NODES + 1);
  localparam int unsigned ADDR_W = (MAX_NODES > 1) ? $clog2(MAX_NODES) : 1;
  localparam int unsigned KEY_W  = CLOCK_BITS + ID_W;

  typedef logic [CLOCK_BITS-1:0] clk_t;

  logic [ID_W-1:0]  own_q;
  clk_t             clock_q, clock_d;
  logic [KEY_W-1:0] key_q, key_d;
  logic             is_insert_q;
  logic [CNT_W-1:0] cnt_q, ptr_q;
  logic             ovf_q, nf_q;
  logic [ID_W-1:0]  head_q;
  logic [KEY_W-1:0] rd_q, wr_data;
  logic [CNT_W-1:0] rd_addr;
  out_item_t        out_q;

  logic [KEY_W-1:0] mem [MAX_NODES];

  clk_t clk_inc, eclk, clk_max, max_inc;

  assign eclk    = CLOCK_BITS'(in_data_i.entry_clock);
  assign clk_inc = (clock_q == '1) ? clock_q : clock_q + 1'b1;
  assign clk_max = (clock_q > eclk) ? clock_q : eclk;
  assign max_inc = (clk_max == '1) ? clk_max : clk_max + 1'b1;

  always_comb begin
    clock_d = clock_q;
    key_d   = {clk_inc, own_q};
    case (in_data_i.func)
      FUNC_LOCAL_REQ: begin
        clock_d = clk_inc;
        key_d   = {clk_inc, own_q};
      end
      FUNC_PEER_REQ: begin
        clock_d = max_inc;
        key_d   = {eclk, in_data_i.entry_id};
      end
      FUNC_PEER_REL: begin
        clock_d = clk_inc;
        key_d   = {clock_q, in_data_i.entry_id};
      end
      FUNC_LOCAL_REL: begin
        key_d   = {clock_q, own_q};
      end
      default: begin
        clock_d = clock_q;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      own_q       <= '0;
      clock_q     <= '0;
      cnt_q       <= '0;
      ptr_q       <= '0;
      ovf_q       <= 1'b0;
      nf_q        <= 1'b0;
      is_insert_q <= 1'b0;
    end else begin
      if (cfg_valid_i) own_q <= cfg_data_i;
      if (cmd_i.accept) begin
        clock_q     <= clock_d;
        is_insert_q <= (in_data_i.func == FUNC_LOCAL_REQ) ||
                       (in_data_i.func == FUNC_PEER_REQ);
        ovf_q       <= 1'b0;
        nf_q        <= 1'b0;
      end
      if (cmd_i.set_ovf) ovf_q <= 1'b1;
      if (cmd_i.set_nf) nf_q <= 1'b1;
      if (cmd_i.cnt_inc) cnt_q <= cnt_q + 1'b1;
      else if (cmd_i.cnt_dec) cnt_q <= cnt_q - 1'b1;
      if (cmd_i.ptr_to_cnt) ptr_q <= cnt_q;
      else if (cmd_i.ptr_to_zero) ptr_q <= '0;
      else if (cmd_i.ptr_dec) ptr_q <= ptr_q - 1'b1;
      else if (cmd_i.ptr_inc) ptr_q <= ptr_q + 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.accept) key_q <= key_d;
  end

  always_comb begin
    case (cmd_i.rd_sel)
      RD_PTR_M1: rd_addr = ptr_q - 1'b1;
      RD_PTR_P1: rd_addr = ptr_q + 1'b1;
      default:   rd_addr = ptr_q;
    endcase
  end

  assign wr_data = cmd_i.wr_new ? key_q : rd_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.wr_en) mem[ptr_q[ADDR_W-1:0]] <= wr_data;
    if (cmd_i.rd_en) rd_q <= mem[rd_addr[ADDR_W-1:0]];
  end

  // shadow of the id in slot 0 for the front test
  always_ff @(posedge clk_i) begin
    if (cmd_i.wr_en && ptr_q == '0) head_q <= wr_data[ID_W-1:0];
  end

  assign sts_o.is_insert       = is_insert_q;
  assign sts_o.is_full         = (cnt_q == CNT_W'(MAX_NODES));
  assign sts_o.ptr_zero        = (ptr_q == '0);
  assign sts_o.ptr_at_cnt      = (ptr_q == cnt_q);
  assign sts_o.ptr_next_at_cnt = (CNT_W'(ptr_q + 1'b1) == cnt_q);
  assign sts_o.rd_greater      = (rd_q > key_q);
  assign sts_o.rd_match        = (rd_q[ID_W-1:0] == key_q[ID_W-1:0]);

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_out) begin
      out_q.clock_now    <= PORT_CLK_W'(clock_q);
      out_q.own_at_front <= (cnt_q != '0) && (head_q == own_q);
      out_q.entry_count  <= PORT_CNT_W'(cnt_q);
      out_q.overflow     <= ovf_q;
      out_q.not_found    <= nf_q;
    end
  end

  assign out_data_o = out_q;

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.cnt_inc |-> (cnt_q < CNT_W'(MAX_NODES)))
    else $error("insert into full queue");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.cnt_dec |-> (cnt_q != '0))
    else $error("remove from empty queue");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.wr_en |-> (ptr_q < CNT_W'(MAX_NODES)))
    else $error("queue write out of range");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.accept |=> (clock_q >= $past(clock_q)))
    else $error("lamport clock went backward");

endmodule
